/* sv/mceb_pkg.sv */
// ----------------------------------------------------------------------------
// mceb_pkg
// shared types, constants and helpers for the color expansion blitter
// ----------------------------------------------------------------------------
package mceb_pkg;

    localparam int unsigned NUM_LANES = 8;

    // largest screen or image dimension; bigger register values clamp to it
    localparam logic [12:0] MAX_DIM = 13'd4096;

    // background value that means "leave the pixel alone"
    localparam logic [31:0] TRANSPARENT_KEY = 32'hFFFF_FFFF;

    // register indexes on the config port
    localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
    localparam logic [2:0] REG_DEST_X        = 3'd2;
    localparam logic [2:0] REG_DEST_Y        = 3'd3;
    localparam logic [2:0] REG_BLIT_WIDTH    = 3'd4;
    localparam logic [2:0] REG_BLIT_HEIGHT   = 3'd5;
    localparam logic [2:0] REG_INK_COLOR     = 3'd6;
    localparam logic [2:0] REG_PAPER_COLOR   = 3'd7;

    // one byte worth of lane decisions, handed to the serializer
    typedef struct packed {
        logic [NUM_LANES-1:0] mask;     // bit i set: lane i writes a pixel
        logic [7:0]           data;     // source byte, bit 7 leftmost
        logic [11:0]          sx_base;  // screen column of lane 0
        logic [11:0]          sy;       // screen row
    } burst_t;

    function automatic logic [12:0] clamp_dim(input logic [12:0] v);
        return (v > MAX_DIM) ? MAX_DIM : v;
    endfunction

endpackage

/* sv/mono_color_expand_blit.sv */
// ----------------------------------------------------------------------------
// mono_color_expand_blit
// expands a 1 bpp bitmap into clipped fg/bg pixel writes in screen coordinates
// ----------------------------------------------------------------------------
//  port group | direction | carries
//  -----------+-----------+-------------------------------------------------
//  s_*        | in        | one bitmap byte per item, bit 7 leftmost
//  m_*        | out       | one pixel write per item: x, y, color, last flag
//  p*         | in/out    | register access, always ready, writes clear position
//
//  eight lanes judge the eight pixels of a byte in the accept cycle; the
//  serializer then sends one pixel write per cycle while m_ready does not
//  stall, only for the visible pixels of a byte (0 to 8)
//  a new byte is taken while the previous one is still being sent out
//  reset (aresetn, synchronous, active low) clears registers and position
//  a stall on m_ready holds the output and back-pressures s_ready
// ----------------------------------------------------------------------------
module mono_color_expand_blit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_bitmap_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [11:0] m_pixel_x,
    output logic [11:0] m_pixel_y,
    output logic [31:0] m_pixel_value,
    output logic        m_last_of_byte
);

    localparam int unsigned NL = mceb_pkg::NUM_LANES;

    logic [12:0] screen_width_reg;
    logic [12:0] screen_height_reg;
    logic [11:0] dest_x_reg;
    logic [11:0] dest_y_reg;
    logic [12:0] blit_width_reg;
    logic [12:0] blit_height_reg;
    logic [31:0] ink_color_reg;
    logic [31:0] paper_color_reg;

    logic [8:0]  byte_col_reg, byte_col_next;
    logic [11:0] src_row_reg, src_row_next;

    logic             a_valid_reg;
    mceb_pkg::burst_t a_burst_reg;
    mceb_pkg::burst_t a_burst_next;

    logic        cfg_wr;
    logic [2:0]  cfg_idx;
    logic        s_acc;
    logic        a_take;

    logic [12:0] width_c;
    logic [12:0] height_c;
    logic [12:0] scr_w_c;
    logic [12:0] scr_h_c;
    logic [9:0]  row_len;
    logic        empty_img;
    logic        transparent;
    logic [12:0] sy;
    logic        row_ok;
    logic [11:0] col_base;
    logic [NL-1:0] lane_emit;
    logic [8:0]  col_inc;
    logic [11:0] row_inc;

    // ---------------- config port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_width_reg  <= '0;
            screen_height_reg <= '0;
            dest_x_reg        <= '0;
            dest_y_reg        <= '0;
            blit_width_reg    <= '0;
            blit_height_reg   <= '0;
            ink_color_reg     <= '0;
            paper_color_reg   <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                mceb_pkg::REG_SCREEN_WIDTH:  screen_width_reg  <= pwdata[12:0];
                mceb_pkg::REG_SCREEN_HEIGHT: screen_height_reg <= pwdata[12:0];
                mceb_pkg::REG_DEST_X:        dest_x_reg        <= pwdata[11:0];
                mceb_pkg::REG_DEST_Y:        dest_y_reg        <= pwdata[11:0];
                mceb_pkg::REG_BLIT_WIDTH:    blit_width_reg    <= pwdata[12:0];
                mceb_pkg::REG_BLIT_HEIGHT:   blit_height_reg   <= pwdata[12:0];
                mceb_pkg::REG_INK_COLOR:     ink_color_reg     <= pwdata;
                mceb_pkg::REG_PAPER_COLOR:   paper_color_reg   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            mceb_pkg::REG_SCREEN_WIDTH:  prdata = 32'(screen_width_reg);
            mceb_pkg::REG_SCREEN_HEIGHT: prdata = 32'(screen_height_reg);
            mceb_pkg::REG_DEST_X:        prdata = 32'(dest_x_reg);
            mceb_pkg::REG_DEST_Y:        prdata = 32'(dest_y_reg);
            mceb_pkg::REG_BLIT_WIDTH:    prdata = 32'(blit_width_reg);
            mceb_pkg::REG_BLIT_HEIGHT:   prdata = 32'(blit_height_reg);
            mceb_pkg::REG_INK_COLOR:     prdata = ink_color_reg;
            mceb_pkg::REG_PAPER_COLOR:   prdata = paper_color_reg;
            default:                     prdata = '0;
        endcase
    end

    // ---------------- geometry ----------------
    assign width_c     = mceb_pkg::clamp_dim(blit_width_reg);
    assign height_c    = mceb_pkg::clamp_dim(blit_height_reg);
    assign scr_w_c     = mceb_pkg::clamp_dim(screen_width_reg);
    assign scr_h_c     = mceb_pkg::clamp_dim(screen_height_reg);
    assign row_len     = 10'((width_c + 13'd7) >> 3);
    assign empty_img   = (width_c == '0) || (height_c == '0);
    assign transparent = (paper_color_reg == mceb_pkg::TRANSPARENT_KEY);
    assign sy          = {1'b0, dest_y_reg} + {1'b0, src_row_reg};
    assign row_ok      = (sy < scr_h_c) && !empty_img;
    assign col_base    = {byte_col_reg, 3'b000};

    // ---------------- lanes ----------------
    for (genvar i = 0; i < NL; i++) begin : g_lane
        mceb_lane #(
            .LANE(i)
        ) u_lane (
            .col_base   (col_base),
            .dest_x     (dest_x_reg),
            .width      (width_c),
            .scr_w      (scr_w_c),
            .row_ok     (row_ok),
            .transparent(transparent),
            .pix_bit    (s_bitmap_byte[NL-1-i]),
            .emit       (lane_emit[i])
        );
    end

    // ---------------- input stage ----------------
    assign s_ready = !a_valid_reg || a_take;
    assign s_acc   = s_valid && s_ready;

    always_comb begin
        a_burst_next.mask    = lane_emit;
        a_burst_next.data    = s_bitmap_byte;
        a_burst_next.sx_base = dest_x_reg + col_base;
        a_burst_next.sy      = sy[11:0];
    end

    // position counters, row length from the clamped width
    assign col_inc = byte_col_reg + 9'd1;
    assign row_inc = src_row_reg + 12'd1;

    always_comb begin
        byte_col_next = byte_col_reg;
        src_row_next  = src_row_reg;
        if (cfg_wr) begin
            byte_col_next = '0;
            src_row_next  = '0;
        end else if (s_acc) begin
            if (empty_img) begin
                byte_col_next = '0;
                src_row_next  = '0;
            end else if (({1'b0, col_inc} >= row_len) || (col_inc == '0)) begin
                byte_col_next = '0;
                if (({1'b0, row_inc} >= height_c) || (row_inc == '0)) begin
                    src_row_next = '0;
                end else begin
                    src_row_next = row_inc;
                end
            end else begin
                byte_col_next = col_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_col_reg <= '0;
            src_row_reg  <= '0;
            a_valid_reg  <= 1'b0;
        end else begin
            byte_col_reg <= byte_col_next;
            src_row_reg  <= src_row_next;
            if (s_acc) begin
                a_valid_reg <= 1'b1;
            end else if (a_take) begin
                a_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            a_burst_reg <= a_burst_next;
        end
    end

    // ---------------- merge / serialize ----------------
    mceb_serializer u_ser (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (a_valid_reg),
        .in_ready        (a_take),
        .in_burst        (a_burst_reg),
        .ink_color       (ink_color_reg),
        .paper_color     (paper_color_reg),
        .out_valid       (m_valid),
        .out_ready       (m_ready),
        .out_pixel_x     (m_pixel_x),
        .out_pixel_y     (m_pixel_y),
        .out_pixel_value (m_pixel_value),
        .out_last_of_byte(m_last_of_byte)
    );

endmodule

/* sv/mceb_lane.sv */
// ----------------------------------------------------------------------------
// mceb_lane
// per-pixel clip and transparency decision for one bit position of a byte
// ----------------------------------------------------------------------------
module mceb_lane #(
    parameter int unsigned LANE = 0
) (
    input  logic [11:0] col_base,
    input  logic [11:0] dest_x,
    input  logic [12:0] width,
    input  logic [12:0] scr_w,
    input  logic        row_ok,
    input  logic        transparent,
    input  logic        pix_bit,
    output logic        emit
);

    logic [12:0] col;
    logic [12:0] sx;

    assign col = {1'b0, col_base} + 13'(LANE);
    assign sx  = {1'b0, dest_x} + col;

    // padding bits, off-screen pixels and transparent background are dropped
    assign emit = (col < width) && (sx < scr_w) && row_ok && (pix_bit || !transparent);

endmodule

/* sv/mceb_serializer.sv */
// ----------------------------------------------------------------------------
// mceb_serializer
// merges the lane mask into one pixel write per cycle while the output is not stalled, leftmost pixel first
// ----------------------------------------------------------------------------
module mceb_serializer (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  mceb_pkg::burst_t     in_burst,
    input  logic [31:0]          ink_color,
    input  logic [31:0]          paper_color,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [11:0]          out_pixel_x,
    output logic [11:0]          out_pixel_y,
    output logic [31:0]          out_pixel_value,
    output logic                 out_last_of_byte
);

    localparam int unsigned NL = mceb_pkg::NUM_LANES;

    mceb_pkg::burst_t cur_reg, cur_next;
    logic             m_valid_reg;
    logic [11:0]      px_reg;
    logic [11:0]      py_reg;
    logic [31:0]      pv_reg;
    logic             last_reg;

    logic             out_free;
    logic             emit;
    logic [NL-1:0]    first;
    logic [2:0]       idx;
    logic [NL-1:0]    mask_after;
    logic             take;

    assign out_free = !m_valid_reg || out_ready;
    assign emit     = (cur_reg.mask != '0) && out_free;

    // lowest set bit is the leftmost pixel still pending
    assign first = cur_reg.mask & (~cur_reg.mask + NL'(1));

    always_comb begin
        idx = '0;
        for (int i = 0; i < NL; i++) begin
            if (first[i]) begin
                idx = 3'(i);
            end
        end
    end

    assign mask_after = emit ? (cur_reg.mask & ~first) : cur_reg.mask;
    assign take       = in_valid && (mask_after == '0);
    assign in_ready   = take;

    always_comb begin
        cur_next      = cur_reg;
        cur_next.mask = mask_after;
        if (take) begin
            cur_next = in_burst;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg.mask <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            cur_reg <= cur_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (out_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            px_reg   <= cur_reg.sx_base + 12'(idx);
            py_reg   <= cur_reg.sy;
            pv_reg   <= cur_reg.data[3'(3'd7 - idx)] ? ink_color : paper_color;
            last_reg <= ((cur_reg.mask & ~first) == '0);
        end
    end

    assign out_valid        = m_valid_reg;
    assign out_pixel_x      = px_reg;
    assign out_pixel_y      = py_reg;
    assign out_pixel_value  = pv_reg;
    assign out_last_of_byte = last_reg;

    a_emit_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> m_valid_reg)
        else $error("pixel write lost on its way to the output register");

    a_mask_drains_one: assert property (@(posedge aclk) disable iff (!aresetn)
        emit && !take |=> $countones(cur_reg.mask) == $countones($past(cur_reg.mask)) - 1)
        else $error("pending mask did not lose exactly one pixel");

    a_stall_holds_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_reg.mask != '0) && !out_free |=> $stable(cur_reg.mask))
        else $error("pending pixels changed while the output was stalled");

    a_last_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        emit && ((cur_reg.mask & ~first) == '0) && !take |=> cur_reg.mask == '0)
        else $error("pixels left over after the last write of an item");

endmodule
